// ===== sv/spq_pkg.sv =====
package spq_pkg;

	localparam int DEPTH_DEFAULT = 32;
	localparam int TAG_BITS_DEFAULT = 16;
	localparam int PRIO_BITS = 3;

	typedef enum logic {
		OP_ENQUEUE = 1'b0,
		OP_DEQUEUE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_HOLD = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic load;
	} dp_cmd_t;

endpackage

// ===== sv/spq_ctrl.sv =====
module spq_ctrl
	import spq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	output logic    rsp_valid,
	input  logic    rsp_ready,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				rsp_valid = 1'b1;
				req_ready = rsp_ready;
				if (rsp_ready && !req_valid) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		cmd.load = req_valid && req_ready;
	end

endmodule

// ===== sv/spq_datapath.sv =====
module spq_datapath
	import spq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT,
	parameter int TAG_BITS = TAG_BITS_DEFAULT,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	input  logic                 operation,
	input  logic [PRIO_BITS-1:0] item_priority,
	input  logic [TAG_BITS-1:0]  item_tag,
	output status_t              status,
	output logic [PRIO_BITS-1:0] out_priority,
	output logic [TAG_BITS-1:0]  out_tag,
	output logic [CW-1:0]        occupancy
);

	logic [PRIO_BITS-1:0] cell_prio_q [DEPTH];
	logic [TAG_BITS-1:0]  cell_tag_q  [DEPTH];
	logic [PRIO_BITS-1:0] cell_prio_d [DEPTH];
	logic [TAG_BITS-1:0]  cell_tag_d  [DEPTH];
	logic [DEPTH-1:0]     behind;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_d;
	logic                 is_full;
	logic                 is_empty;
	status_t              status_d;
	status_t              status_q;
	logic [PRIO_BITS-1:0] out_priority_d;
	logic [PRIO_BITS-1:0] out_priority_q;
	logic [TAG_BITS-1:0]  out_tag_d;
	logic [TAG_BITS-1:0]  out_tag_q;
	logic [CW-1:0]        occupancy_q;

	assign is_full = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);

	// A cell is behind the new word when it is unused or holds a larger priority.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			behind[i] = (CW'(i) >= count_q) || (cell_prio_q[i] > item_priority);
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_prio_d[i] = cell_prio_q[i];
			cell_tag_d[i] = cell_tag_q[i];
		end
		count_d = count_q;
		status_d = STATUS_OK;
		out_priority_d = '0;
		out_tag_d = '0;
		if (operation == OP_ENQUEUE) begin
			if (is_full) begin
				status_d = STATUS_FULL;
			end else begin
				count_d = count_q + CW'(1);
				if (behind[0]) begin
					cell_prio_d[0] = item_priority;
					cell_tag_d[0] = item_tag;
				end
				for (int i = 1; i < DEPTH; i++) begin
					if (behind[i]) begin
						if (!behind[i-1]) begin
							cell_prio_d[i] = item_priority;
							cell_tag_d[i] = item_tag;
						end else begin
							cell_prio_d[i] = cell_prio_q[i-1];
							cell_tag_d[i] = cell_tag_q[i-1];
						end
					end
				end
			end
		end else begin
			if (is_empty) begin
				status_d = STATUS_EMPTY;
			end else begin
				count_d = count_q - CW'(1);
				out_priority_d = cell_prio_q[0];
				out_tag_d = cell_tag_q[0];
				for (int i = 0; i < DEPTH - 1; i++) begin
					cell_prio_d[i] = cell_prio_q[i+1];
					cell_tag_d[i] = cell_tag_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < DEPTH; i++) begin
				cell_prio_q[i] <= cell_prio_d[i];
				cell_tag_q[i] <= cell_tag_d[i];
			end
			status_q <= status_d;
			out_priority_q <= out_priority_d;
			out_tag_q <= out_tag_d;
			occupancy_q <= count_d;
		end
	end

	assign status = status_q;
	assign out_priority = out_priority_q;
	assign out_tag = out_tag_q;
	assign occupancy = occupancy_q;

endmodule

// ===== sv/stable_priority_queue.sv =====
// Sorted priority queue of DEPTH entries held in a row of shift cells; the lowest
// priority value is served first and equal priorities leave in arrival order. Each
// request word either enqueues an item or dequeues the head, and every request
// returns exactly one response word with a status, the dequeued item and the
// occupancy after the operation. All cells compare against the new priority and shift
// in parallel, and the response is registered, so a new request is taken every cycle
// while responses are drained. Enqueue on a full queue and dequeue on an empty queue
// leave the contents untouched and report it.
module stable_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT,
	parameter int TAG_BITS = TAG_BITS_DEFAULT,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic                 operation,
	input  logic [PRIO_BITS-1:0] item_priority,
	input  logic [TAG_BITS-1:0]  item_tag,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output status_t              status,
	output logic [PRIO_BITS-1:0] out_priority,
	output logic [TAG_BITS-1:0]  out_tag,
	output logic [CW-1:0]        occupancy
);

	dp_cmd_t cmd;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	spq_datapath #(
		.DEPTH    (DEPTH),
		.TAG_BITS (TAG_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.operation     (operation),
		.item_priority (item_priority),
		.item_tag      (item_tag),
		.status        (status),
		.out_priority  (out_priority),
		.out_tag       (out_tag),
		.occupancy     (occupancy)
	);

endmodule

// ===== bench/tb_stable_priority_queue.sv =====
module tb_stable_priority_queue;
	import spq_pkg::*;

	localparam int QDEPTH = DEPTH_DEFAULT;
	localparam int TAG_W = TAG_BITS_DEFAULT;
	localparam int OCC_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		status_t              status;
		logic [PRIO_BITS-1:0] prio;
		logic [TAG_W-1:0]     tag;
		logic [OCC_W-1:0]     occ;
	} queue_rsp_t;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_ready;
	logic                 operation;
	logic [PRIO_BITS-1:0] item_priority;
	logic [TAG_W-1:0]     item_tag;
	logic                 rsp_valid;
	logic                 rsp_ready;
	status_t              status;
	logic [PRIO_BITS-1:0] out_priority;
	logic [TAG_W-1:0]     out_tag;
	logic [OCC_W-1:0]     occupancy;

	logic [PRIO_BITS-1:0] shadow_prio [QDEPTH];
	logic [TAG_W-1:0]     shadow_tag [QDEPTH];
	int                   shadow_count;
	queue_rsp_t           awaited_rsp [$];
	int                   mismatches;
	bit                   source_gaps_on;
	bit                   sink_stalls_on;

	stable_priority_queue #(
		.DEPTH(QDEPTH),
		.TAG_BITS(TAG_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.operation(operation),
		.item_priority(item_priority),
		.item_tag(item_tag),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.out_priority(out_priority),
		.out_tag(out_tag),
		.occupancy(occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// A new item goes behind every stored entry of equal or lower priority value.
	function automatic queue_rsp_t shadow_queue_update(op_t op, logic [PRIO_BITS-1:0] p,
			logic [TAG_W-1:0] t);
		queue_rsp_t r;
		int pos;
		int i;
		r.status = STATUS_OK;
		r.prio = '0;
		r.tag = '0;
		if (op == OP_ENQUEUE) begin
			if (shadow_count >= QDEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				pos = 0;
				while (pos < shadow_count && shadow_prio[pos] <= p)
					pos++;
				for (i = shadow_count; i > pos; i--) begin
					shadow_prio[i] = shadow_prio[i-1];
					shadow_tag[i] = shadow_tag[i-1];
				end
				shadow_prio[pos] = p;
				shadow_tag[pos] = t;
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				r.prio = shadow_prio[0];
				r.tag = shadow_tag[0];
				for (i = 1; i < shadow_count; i++) begin
					shadow_prio[i-1] = shadow_prio[i];
					shadow_tag[i-1] = shadow_tag[i];
				end
				shadow_count--;
			end
		end
		r.occ = OCC_W'(shadow_count);
		return r;
	endfunction

	function automatic int source_gap();
		int r;
		if (!source_gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_word(op_t op, logic [PRIO_BITS-1:0] p, logic [TAG_W-1:0] t);
		int gap;
		gap = source_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		item_priority <= p;
		item_tag <= t;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		awaited_rsp.push_back(shadow_queue_update(op, p, t));
	endtask

	task automatic send_random(int enq_pct, int prio_lo, int prio_hi);
		op_t op;
		op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
		send_word(op, PRIO_BITS'($urandom_range(prio_lo, prio_hi)),
			TAG_W'($urandom_range(0, 65535)));
	endtask

	task automatic wait_for_drain();
		int guard;
		guard = 0;
		while (awaited_rsp.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	// Response pacing: mostly ready, with short stalls and the odd long one.
	initial begin
		int stall_left;
		int r;
		stall_left = 0;
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else if (!sink_stalls_on) begin
				rsp_ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 80) begin
					rsp_ready <= 1'b1;
				end else begin
					rsp_ready <= 1'b0;
					stall_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
				end
			end
		end
	end

	always @(posedge clk) begin : rsp_check
		queue_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_rsp.size() == 0) begin
				mismatches++;
				$display("%0t unexpected response word: status %0d occupancy %0d",
					$time, status, occupancy);
			end else begin
				want = awaited_rsp.pop_front();
				if (status !== want.status) begin
					mismatches++;
					$display("%0t status: expected %0d, actual %0d",
						$time, want.status, status);
				end
				if (out_priority !== want.prio) begin
					mismatches++;
					$display("%0t out_priority: expected %0d, actual %0d",
						$time, want.prio, out_priority);
				end
				if (out_tag !== want.tag) begin
					mismatches++;
					$display("%0t out_tag: expected %h, actual %h",
						$time, want.tag, out_tag);
				end
				if (occupancy !== want.occ) begin
					mismatches++;
					$display("%0t occupancy: expected %0d, actual %0d",
						$time, want.occ, occupancy);
				end
			end
		end
	end

	// Tie order, extreme priorities and tags, and dequeue on an empty queue.
	task automatic test_directed_edges();
		send_word(OP_DEQUEUE, '0, '0);
		send_word(OP_ENQUEUE, 3'd7, 16'hFFFF);
		send_word(OP_ENQUEUE, 3'd0, 16'h0000);
		send_word(OP_ENQUEUE, 3'd7, 16'h0001);
		send_word(OP_ENQUEUE, 3'd3, 16'hAAAA);
		send_word(OP_ENQUEUE, 3'd3, 16'h5555);
		send_word(OP_ENQUEUE, 3'd0, 16'hFFFF);
		repeat (6) send_word(OP_DEQUEUE, 3'd7, 16'hFFFF);
		send_word(OP_DEQUEUE, 3'd5, 16'h1234);
		send_word(OP_ENQUEUE, 3'd5, 16'h8001);
		send_word(OP_DEQUEUE, '0, '0);
		send_word(OP_DEQUEUE, 3'd7, 16'hFFFF);
	endtask

	task automatic test_fill_to_full_and_drain();
		int hi;
		int extra;
		repeat (3) begin
			hi = $urandom_range(0, 7);
			extra = $urandom_range(1, 3);
			repeat (QDEPTH - shadow_count + extra)
				send_random(100, 0, hi);
			send_random(50, 0, 7);
			extra = $urandom_range(1, 2);
			repeat (shadow_count + extra)
				send_random(0, 0, 7);
		end
	endtask

	task automatic test_random_mix();
		int phase;
		for (phase = 0; phase < 9; phase++) begin
			source_gaps_on = ($urandom_range(0, 3) != 0);
			sink_stalls_on = ($urandom_range(0, 3) != 0);
			repeat (80)
				send_random((phase % 2 == 0) ? 75 : 25, 0, 7);
		end
		source_gaps_on = 1'b1;
		sink_stalls_on = 1'b1;
	endtask

	task automatic test_equal_priority_runs();
		int a;
		int b;
		int n;
		for (n = 0; n < 200; n++) begin
			if (n % 50 == 0) begin
				a = $urandom_range(0, 7);
				b = $urandom_range(0, 7);
			end
			send_word(($urandom_range(0, 99) < 58) ? OP_ENQUEUE : OP_DEQUEUE,
				PRIO_BITS'(($urandom_range(0, 1) != 0) ? a : b),
				TAG_W'($urandom_range(0, 65535)));
		end
	endtask

	task automatic test_back_to_back();
		source_gaps_on = 1'b0;
		sink_stalls_on = 1'b0;
		repeat (100) send_random(70, 0, 7);
		repeat (100) send_random(30, 0, 7);
		sink_stalls_on = 1'b1;
		repeat (100) send_random(50, 0, 7);
		source_gaps_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		operation = OP_ENQUEUE;
		item_priority = '0;
		item_tag = '0;
		shadow_count = 0;
		mismatches = 0;
		source_gaps_on = 1'b1;
		sink_stalls_on = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_fill_to_full_and_drain();
		test_random_mix();
		// The sender holds off here until every pending response word has come back.
		req_valid <= 1'b0;
		wait_for_drain();
		test_equal_priority_runs();
		test_back_to_back();
		req_valid <= 1'b0;
		wait_for_drain();
		repeat (5) @(posedge clk);
		if (mismatches == 0 && awaited_rsp.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
